[rtl/pls_pkg.sv]
// Package with shared widths, register indexes, types and the score ordering function.
package pls_pkg;

	localparam int unsigned EmbedW   = 8;
	localparam int unsigned NeighW   = 16;
	localparam int unsigned LagW     = 8;
	localparam int unsigned ScoreW   = 32;
	localparam int unsigned ModeW    = 2;
	localparam int unsigned TolW     = 10;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 10;
	localparam int unsigned DiffW    = ScoreW + 1;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_PRIORITY_MODE   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_EQUAL_TOLERANCE = 2'd1;

	// Priority modes: comparison order of the three scores.
	localparam logic [ModeW-1:0] MODE_POS_DARK_NEG = 2'd0;
	localparam logic [ModeW-1:0] MODE_NEG_DARK_POS = 2'd1;
	localparam logic [ModeW-1:0] MODE_DARK_POS_NEG = 2'd2;

	localparam logic [ModeW-1:0] RESET_MODE = MODE_POS_DARK_NEG;
	localparam logic [TolW-1:0]  RESET_TOL  = 10'd1;

	typedef logic signed [ScoreW-1:0] score_t;

	// Scores arranged in comparison order, highest priority first.
	typedef struct packed {
		score_t primary;
		score_t secondary;
		score_t tertiary;
	} ordered_t;

	// One candidate row as captured in the input register.
	typedef struct packed {
		logic              first_row;
		logic              last_row;
		logic [EmbedW-1:0] embed_dim;
		logic [NeighW-1:0] neighbours;
		logic [LagW-1:0]   lag_value;
		score_t            pos_score;
		score_t            neg_score;
		score_t            dark_score;
	} row_t;

	// Current choice of the scan.
	typedef struct packed {
		logic [EmbedW-1:0] embed_dim;
		logic [NeighW-1:0] neighbours;
		logic [LagW-1:0]   lag_value;
		logic              tie;
	} pick_t;

	// Arrange the three scores in the order the mode asks for; the unused code acts as mode 0.
	function automatic ordered_t order_scores(input logic [ModeW-1:0] mode,
		input score_t pos, input score_t neg, input score_t dark);
		ordered_t o;
		case (mode)
			MODE_NEG_DARK_POS: begin
				o.primary = neg;  o.secondary = dark; o.tertiary = pos;
			end
			MODE_DARK_POS_NEG: begin
				o.primary = dark; o.secondary = pos;  o.tertiary = neg;
			end
			default: begin
				o.primary = pos;  o.secondary = dark; o.tertiary = neg;
			end
		endcase
		return o;
	endfunction

endpackage

[rtl/pls_ifs.sv]
// Valid/ready channel interfaces for rows, results and configuration writes.
interface pls_row_if;
	logic                       valid;
	logic                       ready;
	logic                       first_row;
	logic                       last_row;
	logic [pls_pkg::EmbedW-1:0] embed_dim;
	logic [pls_pkg::NeighW-1:0] neighbours;
	logic [pls_pkg::LagW-1:0]   lag_value;
	pls_pkg::score_t            pos_score;
	pls_pkg::score_t            neg_score;
	pls_pkg::score_t            dark_score;

	modport source (output valid, first_row, last_row, embed_dim, neighbours, lag_value,
		pos_score, neg_score, dark_score, input ready);
	modport sink (input valid, first_row, last_row, embed_dim, neighbours, lag_value,
		pos_score, neg_score, dark_score, output ready);
endinterface

interface pls_result_if;
	logic                       valid;
	logic                       ready;
	logic [pls_pkg::EmbedW-1:0] best_embed_dim;
	logic [pls_pkg::NeighW-1:0] best_neighbours;
	logic [pls_pkg::LagW-1:0]   best_lag;
	logic                       tie_seen;

	modport source (output valid, best_embed_dim, best_neighbours, best_lag, tie_seen,
		input ready);
	modport sink (input valid, best_embed_dim, best_neighbours, best_lag, tie_seen,
		output ready);
endinterface

interface pls_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pls_pkg::CfgIdxW-1:0]  index;
	logic [pls_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/priority_lexicographic_selector.sv]
// Top level of the lexicographic best-row selector with tolerance-based ties.
// Rows stream in at one per cycle unless the input register is held. An accepted
// row sits in an input register, where three 33-bit subtract-and-compare checks
// against the stored best scores and one (E, tau, k) tuple compare decide whether
// it replaces the best, joins the tie set or is dropped; when the input register
// moves on, the result of a last row is loaded into an output register. The block
// keeps taking rows while a result waits, holding back only when a second last row
// finds the output register still full.
// Configuration writes are always accepted and must be made between scans.
module priority_lexicographic_selector (
	input  logic             clk,
	input  logic             arst_n,
	pls_cfg_if.sink          cfg,
	pls_row_if.sink          rows,
	pls_result_if.source     result
);

	logic [pls_pkg::ModeW-1:0] mode_q;
	logic [pls_pkg::TolW-1:0]  tol_q;

	pls_pkg::row_t     row_s1;
	logic              valid_s1;
	logic              adv_s1;
	logic              fire_s1;

	pls_pkg::ordered_t ref_q;
	pls_pkg::pick_t    pick_q;

	pls_pkg::ordered_t cur_ord;
	pls_pkg::pick_t    pick_nxt;
	pls_pkg::ordered_t ref_nxt;

	logic signed [pls_pkg::DiffW-1:0] diff [3];
	logic signed [pls_pkg::DiffW-1:0] tol_pos;
	logic signed [pls_pkg::DiffW-1:0] tol_neg;
	logic [2:0] above;
	logic [2:0] below;
	logic       better;
	logic       tie_all;
	logic       smaller;

	logic       out_valid_q;
	pls_pkg::pick_t out_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pls_pkg::RESET_MODE;
			tol_q  <= pls_pkg::RESET_TOL;
		end else if (cfg.valid) begin
			case (cfg.index)
				pls_pkg::REG_PRIORITY_MODE:   mode_q <= cfg.data[pls_pkg::ModeW-1:0];
				pls_pkg::REG_EQUAL_TOLERANCE: tol_q  <= cfg.data[pls_pkg::TolW-1:0];
				default: ;
			endcase
		end
	end

	// The input register moves on unless a last row waits for a full output register.
	assign adv_s1     = !(row_s1.last_row && out_valid_q && !result.ready);
	assign fire_s1    = valid_s1 && adv_s1;
	assign rows.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rows.ready) begin
			valid_s1 <= rows.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rows.ready && rows.valid) begin
			row_s1 <= '{first_row: rows.first_row, last_row: rows.last_row,
				embed_dim: rows.embed_dim, neighbours: rows.neighbours,
				lag_value: rows.lag_value, pos_score: rows.pos_score,
				neg_score: rows.neg_score, dark_score: rows.dark_score};
		end
	end

	// Scores of the row in comparison order and their differences to the references.
	assign cur_ord = pls_pkg::order_scores(mode_q, row_s1.pos_score, row_s1.neg_score,
		row_s1.dark_score);
	assign tol_pos = signed'({{(pls_pkg::DiffW - pls_pkg::TolW){1'b0}}, tol_q});
	assign tol_neg = -tol_pos;

	always_comb begin
		diff[0] = pls_pkg::DiffW'(cur_ord.primary)   - pls_pkg::DiffW'(ref_q.primary);
		diff[1] = pls_pkg::DiffW'(cur_ord.secondary) - pls_pkg::DiffW'(ref_q.secondary);
		diff[2] = pls_pkg::DiffW'(cur_ord.tertiary)  - pls_pkg::DiffW'(ref_q.tertiary);
		for (int p = 0; p < 3; p++) begin
			above[p] = diff[p] > tol_pos;
			below[p] = diff[p] < tol_neg;
		end
	end

	// The first score outside the tolerance band decides; none outside means a tie.
	always_comb begin
		if (above[0] || below[0]) begin
			better = above[0];
		end else if (above[1] || below[1]) begin
			better = above[1];
		end else begin
			better = above[2];
		end
		tie_all = !(|above) && !(|below);
		smaller = (row_s1.embed_dim < pick_q.embed_dim) ||
			(row_s1.embed_dim == pick_q.embed_dim && row_s1.lag_value < pick_q.lag_value) ||
			(row_s1.embed_dim == pick_q.embed_dim && row_s1.lag_value == pick_q.lag_value &&
			 row_s1.neighbours < pick_q.neighbours);
	end

	// Next best row and references.
	always_comb begin
		ref_nxt  = ref_q;
		pick_nxt = pick_q;
		if (row_s1.first_row || better) begin
			ref_nxt  = cur_ord;
			pick_nxt = '{embed_dim: row_s1.embed_dim, neighbours: row_s1.neighbours,
				lag_value: row_s1.lag_value, tie: 1'b0};
		end else if (tie_all) begin
			pick_nxt.tie = 1'b1;
			if (smaller) begin
				pick_nxt.embed_dim  = row_s1.embed_dim;
				pick_nxt.neighbours = row_s1.neighbours;
				pick_nxt.lag_value  = row_s1.lag_value;
			end
		end
	end

	// Scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= '0;
			pick_q <= '0;
		end else if (fire_s1) begin
			ref_q  <= ref_nxt;
			pick_q <= pick_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && row_s1.last_row) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && row_s1.last_row) begin
			out_q <= pick_nxt;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.best_embed_dim  = out_q.embed_dim;
	assign result.best_neighbours = out_q.neighbours;
	assign result.best_lag        = out_q.lag_value;
	assign result.tie_seen        = out_q.tie;

endmodule

[rtl/pls_checker.sv]
// Port-level checker for the selector and its bind to the top level.
module pls_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       row_valid,
	input logic                       row_ready,
	input logic                       row_first,
	input logic                       row_last,
	input logic [pls_pkg::EmbedW-1:0] row_embed_dim,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [pls_pkg::EmbedW-1:0] res_embed_dim,
	input logic                       res_tie
);

	logic row_acc;
	assign row_acc = row_valid && row_ready;

	// A pending result stays offered until the transaction completes.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn before its transaction completed");

	// With no result pending the block always takes a row.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> row_ready)
		else $error("rows stalled while the output register is empty");

	// A new result appears only after a last row was accepted.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(row_acc && row_last, 2))
		else $error("result without a preceding last row");

	// A single-row scan reports that row without a tie.
	a_single_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) && $past(row_acc && row_first && row_last, 2) |->
			!res_tie && res_embed_dim == $past(row_embed_dim, 2))
		else $error("single-row scan reported a wrong result");

endmodule

bind priority_lexicographic_selector pls_checker u_pls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.row_valid     (rows.valid),
	.row_ready     (rows.ready),
	.row_first     (rows.first_row),
	.row_last      (rows.last_row),
	.row_embed_dim (rows.embed_dim),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_embed_dim (result.best_embed_dim),
	.res_tie       (result.tie_seen)
);
